@@ rtl/mtet_pkg.sv @@
`timescale 1ns / 1ps

package mtet_pkg;

  localparam int COORD_W = 16;
  localparam int DIST_W = 17;
  localparam int THR_W = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [4:0] EV_SYNC = 5'd0;
  localparam logic [4:0] EV_ABS = 5'd3;

  localparam logic [9:0] CODE_FRAME = 10'd0;
  localparam logic [9:0] CODE_CONTACT = 10'd2;
  localparam logic [9:0] CODE_POS_X = 10'h035;
  localparam logic [9:0] CODE_POS_Y = 10'h036;
  localparam logic [9:0] CODE_TRACK_ID = 10'h039;

  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GHOST_DIST = 2'd2;

  localparam logic [THR_W-1:0] MOVE_THR_RST = 17'd10;
  localparam logic [THR_W-1:0] STOP_THR_RST = 17'd5;
  localparam logic [THR_W-1:0] GHOST_DIST_RST = 17'd20;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_MOVING   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_MOVING  = 2'd2,
    KIND_STOPPED = 2'd3
  } kind_t;

  typedef struct packed {
    phase_t               phase;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
  } entry_t;

endpackage

@@ rtl/mtet_ram.sv @@
`timescale 1ns / 1ps

module mtet_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mtet_dist.sv @@
`timescale 1ns / 1ps

module mtet_dist import mtet_pkg::*; (
  input  logic               clk,
  input  logic [COORD_W-1:0] pend_x,
  input  logic [COORD_W-1:0] pend_y,
  input  entry_t             own,
  input  entry_t             oth,
  output logic [DIST_W-1:0]  dist_own,
  output logic [DIST_W-1:0]  dist_oth
);

  logic [COORD_W-1:0] dx_own, dy_own, dx_oth, dy_oth;
  logic [DIST_W-1:0]  dist_own_r, dist_oth_r;
  logic [DIST_W-1:0]  dist_own_nxt, dist_oth_nxt;

  always_comb begin
    dx_own = (pend_x > own.x) ? pend_x - own.x : own.x - pend_x;
    dy_own = (pend_y > own.y) ? pend_y - own.y : own.y - pend_y;
    dx_oth = (pend_x > oth.x) ? pend_x - oth.x : oth.x - pend_x;
    dy_oth = (pend_y > oth.y) ? pend_y - oth.y : oth.y - pend_y;
    dist_own_nxt = {1'b0, dx_own} + {1'b0, dy_own};
    dist_oth_nxt = {1'b0, dx_oth} + {1'b0, dy_oth};
  end

  always_ff @(posedge clk) begin
    dist_own_r <= dist_own_nxt;
    dist_oth_r <= dist_oth_nxt;
  end

  assign dist_own = dist_own_r;
  assign dist_oth = dist_oth_r;

endmodule

@@ rtl/multitouch_event_tracker_unit.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    event_type, event_code, event_value
// out      output     out_valid / out_stall  kind, finger, pos_x, pos_y, last_of_run
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// Axis events, and contact reports for an out-of-range id, leave the sequencer idle. Other
// contact reports step through S_CRD1, S_CRD2 (fingers 0 and 1 only), S_CDIST and S_CEXE,
// then S_COUT once per result. A frame report visits one slot per cycle in S_FISS and reads
// each released finger in S_FDAT, where a stalled output holds it; the single table port
// sets this. Reset is synchronous and returns all fingers to released.
// A stalled output holds the sequencer until the pending result transfers.

module multitouch_event_tracker_unit import mtet_pkg::*; #(
  parameter int FINGER_SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [4:0]            in_event_type,
  input  logic [9:0]            in_event_code,
  input  logic signed [31:0]    in_event_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [3:0]            out_finger,
  output logic [15:0]           out_pos_x,
  output logic [15:0]           out_pos_y,
  output logic                  out_last_of_run,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [THR_W-1:0]      cfg_wdata
);

  localparam int IDW = $clog2(FINGER_SLOTS);
  localparam int EW = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRD1,
    S_CRD2,
    S_CDIST,
    S_CEXE,
    S_COUT,
    S_FISS,
    S_FDAT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [THR_W-1:0]        mv_thr_r, mv_thr_nxt;
  logic [THR_W-1:0]        st_thr_r, st_thr_nxt;
  logic [THR_W-1:0]        gh_thr_r, gh_thr_nxt;
  logic [COORD_W-1:0]      pend_x_r, pend_x_nxt;
  logic [COORD_W-1:0]      pend_y_r, pend_y_nxt;
  logic [1:0]              fresh_r, fresh_nxt;
  logic                    cur_ok_r, cur_ok_nxt;
  logic [IDW-1:0]          cur_slot_r, cur_slot_nxt;
  logic [FINGER_SLOTS-1:0] seen_r, seen_nxt;
  logic [FINGER_SLOTS-1:0] active_r, active_nxt;
  logic [FINGER_SLOTS-1:0] vld_r, vld_nxt;
  logic [IDW-1:0]          slot_r, slot_nxt;
  logic [IDW-1:0]          rd_addr_r, rd_addr_nxt;
  entry_t                  own_r, own_nxt;
  entry_t                  oth_r, oth_nxt;
  logic                    em_press_r, em_press_nxt;
  logic                    em_mv_r, em_mv_nxt;
  logic                    em_st_r, em_st_nxt;
  logic                    out_valid_r, out_valid_nxt;
  kind_t                   out_kind_r, out_kind_nxt;
  logic [IDW-1:0]          out_slot_r, out_slot_nxt;
  logic [COORD_W-1:0]      out_x_r, out_x_nxt;
  logic [COORD_W-1:0]      out_y_r, out_y_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    accept;
  logic                    out_free;
  logic [FINGER_SLOTS-1:0] rel_mask;
  logic                    ram_we, ram_re;
  logic [IDW-1:0]          ram_waddr, ram_raddr;
  entry_t                  ram_wdata;
  logic [EW-1:0]           ram_rdata;
  entry_t                  rd_entry;
  logic [DIST_W-1:0]       dist_own, dist_oth;
  logic                    is_pair, scan_end, run_last;
  logic                    mv, st, ghost_ok;
  phase_t                  ph1, ph2;
  logic [IDW+3:0]          slot_ext;
  logic [COORD_W-1:0]      sat_val;

  mtet_ram #(
    .WIDTH (EW),
    .DEPTH (FINGER_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mtet_dist u_dist (
    .clk      (clk),
    .pend_x   (pend_x_r),
    .pend_y   (pend_y_r),
    .own      (own_r),
    .oth      (oth_r),
    .dist_own (dist_own),
    .dist_oth (dist_oth)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign rel_mask = active_r & ~seen_r;
  assign rd_entry = vld_r[rd_addr_r] ? entry_t'(ram_rdata) : entry_t'('0);
  assign is_pair = ({1'b0, slot_r} < (IDW + 1)'(2));
  assign scan_end = ({1'b0, slot_r} == (IDW + 1)'(FINGER_SLOTS - 1));
  assign run_last = ((rel_mask >> slot_r) >> 1) == '0;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (in_event_value[31]) begin
      sat_val = '0;
    end else if (|in_event_value[30:16]) begin
      sat_val = '1;
    end else begin
      sat_val = in_event_value[15:0];
    end
  end

  always_comb begin
    mv = (own_r.phase == PH_PRESSED) && (dist_own > mv_thr_r);
    ph1 = mv ? PH_MOVING : own_r.phase;
    st = (ph1 == PH_MOVING) && (dist_own < st_thr_r);
    ph2 = st ? PH_PRESSED : ph1;
    ghost_ok = is_pair && ((oth_r.phase == PH_RELEASED) || (dist_oth > gh_thr_r));
  end

  always_comb begin
    state_nxt = state_r;
    mv_thr_nxt = mv_thr_r;
    st_thr_nxt = st_thr_r;
    gh_thr_nxt = gh_thr_r;
    pend_x_nxt = pend_x_r;
    pend_y_nxt = pend_y_r;
    fresh_nxt = fresh_r;
    cur_ok_nxt = cur_ok_r;
    cur_slot_nxt = cur_slot_r;
    seen_nxt = seen_r;
    active_nxt = active_r;
    vld_nxt = vld_r;
    slot_nxt = slot_r;
    rd_addr_nxt = rd_addr_r;
    own_nxt = own_r;
    oth_nxt = oth_r;
    em_press_nxt = em_press_r;
    em_mv_nxt = em_mv_r;
    em_st_nxt = em_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt = out_kind_r;
    out_slot_nxt = out_slot_r;
    out_x_nxt = out_x_r;
    out_y_nxt = out_y_r;
    out_last_nxt = out_last_r;
    ram_we = 1'b0;
    ram_waddr = slot_r;
    ram_wdata = rd_entry;
    ram_re = 1'b0;
    ram_raddr = slot_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_MOVE_THR:   mv_thr_nxt = cfg_wdata;
        CFG_STOP_THR:   st_thr_nxt = cfg_wdata;
        CFG_GHOST_DIST: gh_thr_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_event_type)
            EV_ABS: begin
              case (in_event_code)
                CODE_POS_X: begin
                  pend_x_nxt = sat_val;
                  fresh_nxt[0] = 1'b1;
                end
                CODE_POS_Y: begin
                  pend_y_nxt = sat_val;
                  fresh_nxt[1] = 1'b1;
                end
                CODE_TRACK_ID: begin
                  cur_ok_nxt = !in_event_value[31] &&
                               (in_event_value[30:0] < 31'(FINGER_SLOTS));
                  cur_slot_nxt = in_event_value[IDW-1:0];
                end
                default: ;
              endcase
            end
            EV_SYNC: begin
              case (in_event_code)
                CODE_CONTACT: begin
                  if (cur_ok_r) begin
                    seen_nxt[cur_slot_r] = 1'b1;
                    ram_re = 1'b1;
                    ram_raddr = cur_slot_r;
                    rd_addr_nxt = cur_slot_r;
                    slot_nxt = cur_slot_r;
                    state_nxt = S_CRD1;
                  end else begin
                    fresh_nxt = 2'b00;
                  end
                end
                CODE_FRAME: begin
                  if (rel_mask != '0) begin
                    slot_nxt = '0;
                    state_nxt = S_FISS;
                  end else begin
                    seen_nxt = '0;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      S_CRD1: begin
        own_nxt = rd_entry;
        if (is_pair) begin
          ram_re = 1'b1;
          ram_raddr = slot_r ^ IDW'(1);
          rd_addr_nxt = slot_r ^ IDW'(1);
          state_nxt = S_CRD2;
        end else begin
          oth_nxt = '0;
          state_nxt = S_CDIST;
        end
      end
      S_CRD2: begin
        oth_nxt = rd_entry;
        state_nxt = S_CDIST;
      end
      S_CDIST: begin
        state_nxt = S_CEXE;
      end
      S_CEXE: begin
        fresh_nxt = 2'b00;
        em_press_nxt = 1'b0;
        em_mv_nxt = 1'b0;
        em_st_nxt = 1'b0;
        state_nxt = S_IDLE;
        if (fresh_r == 2'b11 && own_r.phase == PH_RELEASED) begin
          ram_we = 1'b1;
          ram_wdata = '{phase: PH_PRESSED, x: pend_x_r, y: pend_y_r};
          active_nxt[slot_r] = 1'b1;
          vld_nxt[slot_r] = 1'b1;
          em_press_nxt = 1'b1;
          state_nxt = S_COUT;
        end else if (own_r.phase == PH_PRESSED || own_r.phase == PH_MOVING) begin
          ram_we = 1'b1;
          ram_wdata.phase = ph2;
          ram_wdata.x = ghost_ok ? pend_x_r : own_r.x;
          ram_wdata.y = ghost_ok ? pend_y_r : own_r.y;
          em_mv_nxt = mv;
          em_st_nxt = st;
          if (mv || st) begin
            state_nxt = S_COUT;
          end
        end
      end
      S_COUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt = slot_r;
          out_x_nxt = '0;
          out_y_nxt = '0;
          if (em_press_r) begin
            out_kind_nxt = KIND_PRESS;
            out_x_nxt = pend_x_r;
            out_y_nxt = pend_y_r;
            out_last_nxt = 1'b1;
            em_press_nxt = 1'b0;
            state_nxt = S_IDLE;
          end else if (em_mv_r) begin
            out_kind_nxt = KIND_MOVING;
            out_last_nxt = !em_st_r;
            em_mv_nxt = 1'b0;
            if (!em_st_r) begin
              state_nxt = S_IDLE;
            end
          end else begin
            out_kind_nxt = KIND_STOPPED;
            out_last_nxt = 1'b1;
            em_st_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      S_FISS: begin
        if (rel_mask[slot_r]) begin
          ram_re = 1'b1;
          ram_raddr = slot_r;
          rd_addr_nxt = slot_r;
          state_nxt = S_FDAT;
        end else if (scan_end) begin
          seen_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      S_FDAT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt = KIND_RELEASE;
          out_slot_nxt = slot_r;
          out_x_nxt = rd_entry.x;
          out_y_nxt = rd_entry.y;
          out_last_nxt = run_last;
          ram_we = 1'b1;
          ram_wdata = '{phase: PH_RELEASED, x: rd_entry.x, y: rd_entry.y};
          active_nxt[slot_r] = 1'b0;
          if (run_last) begin
            seen_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            slot_nxt = slot_r + 1'b1;
            state_nxt = S_FISS;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mv_thr_r <= MOVE_THR_RST;
      st_thr_r <= STOP_THR_RST;
      gh_thr_r <= GHOST_DIST_RST;
      pend_x_r <= '0;
      pend_y_r <= '0;
      fresh_r <= 2'b00;
      cur_ok_r <= 1'b1;
      cur_slot_r <= '0;
      seen_r <= '0;
      active_r <= '0;
      vld_r <= '0;
      em_press_r <= 1'b0;
      em_mv_r <= 1'b0;
      em_st_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mv_thr_r <= mv_thr_nxt;
      st_thr_r <= st_thr_nxt;
      gh_thr_r <= gh_thr_nxt;
      pend_x_r <= pend_x_nxt;
      pend_y_r <= pend_y_nxt;
      fresh_r <= fresh_nxt;
      cur_ok_r <= cur_ok_nxt;
      cur_slot_r <= cur_slot_nxt;
      seen_r <= seen_nxt;
      active_r <= active_nxt;
      vld_r <= vld_nxt;
      em_press_r <= em_press_nxt;
      em_mv_r <= em_mv_nxt;
      em_st_r <= em_st_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r <= slot_nxt;
    rd_addr_r <= rd_addr_nxt;
    own_r <= own_nxt;
    oth_r <= oth_nxt;
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  assign slot_ext = {4'b0000, out_slot_r};
  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_finger = slot_ext[3:0];
  assign out_pos_x = out_x_r;
  assign out_pos_y = out_y_r;
  assign out_last_of_run = out_last_r;

`ifndef SYNTHESIS
  a_active_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r & ~vld_r) == '0)
    else $error("Active finger without a written table entry.");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |-> state_r != S_IDLE)
    else $error("Result run left open while the sequencer is idle.");

  a_fresh_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CEXE |=> fresh_r == 2'b00)
    else $error("Fresh position flags not cleared after a contact report.");
`endif

endmodule

@@ tb/sv/multitouch_event_tracker_unit_tb.sv @@
`timescale 1ns / 1ps

module multitouch_event_tracker_unit_tb;
  import mtet_pkg::*;

  localparam int SLOTS = 16;
  localparam int HOLD_CYCLES = 500;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 10;
  localparam int IDLE_LIMIT = 4000;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    kind_t              kind;
    logic [3:0]         finger;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } touch_report_t;

  class touch_scoreboard;
    logic [THR_W-1:0]   move_thr;
    logic [THR_W-1:0]   stop_thr;
    logic [THR_W-1:0]   ghost_dist;
    phase_t             phase [SLOTS];
    logic [COORD_W-1:0] fx [SLOTS];
    logic [COORD_W-1:0] fy [SLOTS];
    logic [SLOTS-1:0]   seen;
    logic [31:0]        cur_id;
    logic [COORD_W-1:0] pend_x;
    logic [COORD_W-1:0] pend_y;
    logic [1:0]         fresh;
    touch_report_t      awaited [$];
    int                 errors;

    function new();
      move_thr = MOVE_THR_RST;
      stop_thr = STOP_THR_RST;
      ghost_dist = GHOST_DIST_RST;
      foreach (phase[i]) begin
        phase[i] = PH_RELEASED;
        fx[i] = '0;
        fy[i] = '0;
      end
      seen = '0;
      cur_id = '0;
      pend_x = '0;
      pend_y = '0;
      fresh = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
      case (idx)
        CFG_MOVE_THR: move_thr = val;
        CFG_STOP_THR: stop_thr = val;
        CFG_GHOST_DIST: ghost_dist = val;
        default: ;
      endcase
    endfunction

    function logic [COORD_W-1:0] clamp_coord(logic signed [31:0] v);
      if (v < 0) return '0;
      if (v > 65535) return '1;
      return v[COORD_W-1:0];
    endfunction

    function logic [DIST_W-1:0] span(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
      return (a > b) ? {1'b0, a - b} : {1'b0, b - a};
    endfunction

    function logic [DIST_W-1:0] dist_from(int slot);
      return span(pend_x, fx[slot]) + span(pend_y, fy[slot]);
    endfunction

    function void add(kind_t kind, int slot, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      touch_report_t r;
      r.kind = kind;
      r.finger = 4'(slot);
      r.x = x;
      r.y = y;
      r.last = 1'b0;
      awaited.push_back(r);
    endfunction

    function void contact_report();
      int id;
      int other;
      logic [DIST_W-1:0] d;
      bit accept;
      if (cur_id < SLOTS) begin
        id = int'(cur_id);
        seen[id] = 1'b1;
        if (fresh == 2'b11 && phase[id] == PH_RELEASED) begin
          phase[id] = PH_PRESSED;
          fx[id] = pend_x;
          fy[id] = pend_y;
          add(KIND_PRESS, id, pend_x, pend_y);
        end else if (phase[id] == PH_PRESSED || phase[id] == PH_MOVING) begin
          d = dist_from(id);
          accept = 1'b0;
          if (phase[id] == PH_PRESSED && d > move_thr) begin
            phase[id] = PH_MOVING;
            add(KIND_MOVING, id, '0, '0);
          end
          if (phase[id] == PH_MOVING && d < stop_thr) begin
            phase[id] = PH_PRESSED;
            add(KIND_STOPPED, id, '0, '0);
          end
          if (id < 2) begin
            other = id ^ 1;
            accept = (phase[other] == PH_RELEASED) || (dist_from(other) > ghost_dist);
          end
          if (accept) begin
            fx[id] = pend_x;
            fy[id] = pend_y;
          end
        end
      end
      fresh = '0;
    endfunction

    function void frame_report();
      for (int s = 0; s < SLOTS; s++) begin
        if (!seen[s] && phase[s] != PH_RELEASED) begin
          phase[s] = PH_RELEASED;
          add(KIND_RELEASE, s, fx[s], fy[s]);
        end
      end
      seen = '0;
    endfunction

    function void take_event(logic [4:0] ev_type, logic [9:0] ev_code,
                             logic signed [31:0] ev_value);
      int before_n;
      touch_report_t r;
      before_n = awaited.size();
      if (ev_type == EV_SYNC) begin
        if (ev_code == CODE_CONTACT) contact_report();
        else if (ev_code == CODE_FRAME) frame_report();
      end else if (ev_type == EV_ABS) begin
        if (ev_code == CODE_POS_X) begin
          pend_x = clamp_coord(ev_value);
          fresh[0] = 1'b1;
        end else if (ev_code == CODE_POS_Y) begin
          pend_y = clamp_coord(ev_value);
          fresh[1] = 1'b1;
        end else if (ev_code == CODE_TRACK_ID) begin
          cur_id = ev_value;
        end
      end
      if (awaited.size() > before_n) begin
        r = awaited.pop_back();
        r.last = 1'b1;
        awaited.push_back(r);
      end
    endfunction

    function void check_report(logic [1:0] kind, logic [3:0] finger, logic [15:0] x,
                               logic [15:0] y, logic last);
      touch_report_t e;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("Unexpected result: kind=%0d finger=%0d x=%0d y=%0d last=%0d",
                   kind, finger, x, y, last);
        return;
      end
      e = awaited.pop_front();
      if (kind !== e.kind || finger !== e.finger || x !== e.x || y !== e.y ||
          last !== e.last) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("Mismatch: expected kind=%0d finger=%0d x=%0d y=%0d last=%0d, got kind=%0d finger=%0d x=%0d y=%0d last=%0d",
                   e.kind, e.finger, e.x, e.y, e.last, kind, finger, x, y, last);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [4:0]           in_event_type = '0;
  logic [9:0]           in_event_code = '0;
  logic signed [31:0]   in_event_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_kind;
  logic [3:0]           out_finger;
  logic [15:0]          out_pos_x;
  logic [15:0]          out_pos_y;
  logic                 out_last_of_run;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0]     cfg_wdata = '0;

  touch_scoreboard sb;
  bit  sender_calm = 1'b0;
  bit  hold_go = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  run_left = 0;
  int  useful_items = 0;
  int  idle_cycles = 0;
  int  walk_x [SLOTS];
  int  walk_y [SLOTS];

  multitouch_event_tracker_unit #(.FINGER_SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_event_type(in_event_type),
    .in_event_code(in_event_code),
    .in_event_value(in_event_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_finger(out_finger),
    .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y),
    .out_last_of_run(out_last_of_run),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int step_coord(int c, int scale);
    int v;
    v = c + int'($urandom_range(0, 2 * scale)) - scale;
    if (v < -50) v = -50;
    if (v > 65600) v = 65600;
    return v;
  endfunction

  task automatic send_event(input logic [4:0] ev_type, input logic [9:0] ev_code,
                            input logic signed [31:0] ev_value);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_event_type <= ev_type;
    in_event_code <= ev_code;
    in_event_value <= ev_value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_event(ev_type, ev_code, ev_value);
    if ((ev_type == EV_SYNC && (ev_code == CODE_CONTACT || ev_code == CODE_FRAME)) ||
        (ev_type == EV_ABS && (ev_code == CODE_POS_X || ev_code == CODE_POS_Y ||
                               ev_code == CODE_TRACK_ID)))
      useful_items++;
  endtask

  task automatic touch(input logic signed [31:0] id, input logic signed [31:0] x,
                       input logic signed [31:0] y);
    send_event(EV_ABS, CODE_TRACK_ID, id);
    send_event(EV_ABS, CODE_POS_X, x);
    send_event(EV_ABS, CODE_POS_Y, y);
    send_event(EV_SYNC, CODE_CONTACT, $urandom());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_thresholds(input logic [THR_W-1:0] move_thr,
                                input logic [THR_W-1:0] stop_thr,
                                input logic [THR_W-1:0] ghost_dist);
    write_reg(CFG_MOVE_THR, move_thr);
    write_reg(CFG_STOP_THR, stop_thr);
    write_reg(CFG_GHOST_DIST, ghost_dist);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_frame(input int scale);
    int n;
    int r;
    int slot;
    int sel;
    logic signed [31:0] tid;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    sender_calm = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 3) == 0)
      send_event(5'($urandom_range(0, 31)), 10'($urandom_range(0, 1023)), $urandom());
    n = $urandom_range(1, 4);
    repeat (n) begin
      r = $urandom_range(0, 99);
      slot = (r < 75) ? $urandom_range(0, 3) : $urandom_range(4, SLOTS - 1);
      tid = slot;
      if (r >= 92)
        tid = ($urandom_range(0, 1) == 0) ? ($urandom() | 32'h8000_0000)
                                          : $urandom_range(SLOTS, 4096);
      if (slot == 1 && $urandom_range(0, 4) == 0) begin
        walk_x[1] = walk_x[0];
        walk_y[1] = walk_y[0];
      end
      walk_x[slot] = step_coord(walk_x[slot], scale);
      walk_y[slot] = step_coord(walk_y[slot], scale);
      vx = ($urandom_range(0, 19) == 0) ? $urandom() : walk_x[slot];
      vy = ($urandom_range(0, 19) == 0) ? $urandom() : walk_y[slot];
      if ($urandom_range(0, 9) != 0) send_event(EV_ABS, CODE_TRACK_ID, tid);
      sel = $urandom_range(0, 11);
      if (sel != 10 && sel != 11) send_event(EV_ABS, CODE_POS_X, vx);
      if (sel != 9 && sel != 11) send_event(EV_ABS, CODE_POS_Y, vy);
      send_event(EV_SYNC, CODE_CONTACT, $urandom());
    end
    if ($urandom_range(0, 9) != 0) send_event(EV_SYNC, CODE_FRAME, $urandom());
  endtask

  task automatic roam(input int amount, input int scale);
    int goal;
    goal = useful_items + amount;
    while (useful_items < goal) random_frame(scale);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_report(out_kind, out_finger, out_pos_x, out_pos_y, out_last_of_run);
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
      out_stall <= 1'b0;
    end else begin
      run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200) : $urandom_range(0, 6);
      stall_left = pick_gap();
      out_stall <= 1'b0;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("multitouch_event_tracker_unit_tb NOT OK");
    $finish;
  end

  initial begin
    sb = new();
    foreach (walk_x[i]) begin
      walk_x[i] = $urandom_range(200, 65000);
      walk_y[i] = $urandom_range(200, 65000);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Saturating press, a ghost-blocked move, then a stop close to the stored point.
    touch(0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    touch(1, 65530, 5);
    touch(0, 65520, 0);
    touch(0, 65534, 1);
    touch(5, 100, 100);
    send_event(EV_ABS, CODE_POS_X, 200);
    send_event(EV_SYNC, CODE_CONTACT, 0);
    send_event(EV_ABS, CODE_POS_X, 102);
    send_event(EV_SYNC, CODE_CONTACT, 0);
    send_event(EV_SYNC, CODE_FRAME, 0);
    send_event(EV_SYNC, CODE_FRAME, 0);
    send_event(EV_ABS, CODE_TRACK_ID, -1);
    send_event(EV_SYNC, CODE_CONTACT, 0);
    send_event(EV_ABS, CODE_TRACK_ID, SLOTS);
    send_event(EV_SYNC, CODE_CONTACT, 0);
    send_event(5'd31, 10'h3FF, 0);
    send_event(EV_ABS, 10'h3FF, -1);
    send_event(EV_SYNC, 10'd1, 0);
    roam(40, 12);

    wait_idle();
    set_thresholds(17'd0, 17'h1FFFF, 17'd0);
    roam(40, 8);

    wait_idle();
    set_thresholds(17'h1FFFF, 17'd0, 17'h1FFFF);
    sender_calm = 1'b1;
    for (int s = 0; s < SLOTS; s++)
      touch(s, $urandom_range(0, 65535), $urandom_range(0, 65535));
    send_event(EV_SYNC, CODE_FRAME, 0);
    hold_go <= 1'b1;
    send_event(EV_SYNC, CODE_FRAME, 0);
    for (int s = 0; s < 6; s++)
      touch(s, $urandom_range(0, 65535), $urandom_range(0, 65535));
    roam(40, 2000);

    wait_idle();
    set_thresholds(17'd40, 17'd15, 17'd60);
    roam(40, 50);

    wait_idle();
    set_thresholds(MOVE_THR_RST, STOP_THR_RST, GHOST_DIST_RST);
    roam(45, 12);

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("multitouch_event_tracker_unit_tb OK");
    end else begin
      $display("multitouch_event_tracker_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
